// ===== hw/rtl/lse_pkg.sv =====
// Shared types, constants and fixed-point helpers of the LPC signal extrapolator.
// Used by the divider and the top level; depends on nothing.
package lse_pkg;

   localparam int ORDER      = 24;
   localparam int RING_DEPTH = 512;
   localparam int RING_AW    = 9;
   localparam int COEF_AW    = 5;
   localparam int ACF_DEPTH  = ORDER + 1;
   localparam int ACF_W      = 48;
   localparam int COEF_W     = 32;
   localparam int COUNT_W    = 10;
   localparam int SAMPLE_W   = 16;

   // divider geometry: magnitude of a 64-bit numerator over a 32-bit error
   localparam int DIV_NUM_W  = 64;
   localparam int DIV_DEN_W  = 32;
   localparam int DIV_CNT_W  = 7;
   localparam int REFL_W     = 25;

   localparam logic [COUNT_W-1:0] MIN_WINDOW       = 10'd96;
   localparam logic [COUNT_W-1:0] HIST_LIMIT_RESET = 10'd480;
   localparam logic signed [31:0] DAMP_Q30         = 32'sd1063004406;
   localparam logic signed [64:0] ACC_BOUND        = 65'sh0_4000_0000_0000_0000;
   localparam logic [23:0]        REFL_MAX         = 24'hFF_FFFF;

   localparam logic [2:0] ADDR_HISTORY_LIMIT = 3'd0;

   typedef enum logic [1:0] {
      KIND_PUSH  = 2'd0,
      KIND_EMIT  = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
      if (v > 65'sh0_0000_0000_7FFF_FFFF)
         return 32'sh7FFF_FFFF;
      if (v < -65'sh0_0000_0000_8000_0000)
         return -32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic signed [63:0] sat_acc(input logic signed [64:0] v);
      if (v > ACC_BOUND)
         return ACC_BOUND[63:0];
      if (v < -ACC_BOUND)
         return 64'(-ACC_BOUND);
      return v[63:0];
   endfunction

   function automatic logic signed [63:0] round24(input logic signed [63:0] v);
      logic signed [63:0] t;
      t = v + 64'sd8388608;
      return t >>> 24;
   endfunction

   function automatic logic signed [63:0] round30(input logic signed [63:0] v);
      logic signed [63:0] t;
      t = v + 64'sd536870912;
      return t >>> 30;
   endfunction

endpackage

// ===== hw/rtl/lse_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
module lse_ram #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

// ===== hw/rtl/lse_div.sv =====
// Serial restoring divider for the reflection coefficient: one quotient bit a cycle,
// truncation toward zero, result clamped to the Q24 range. Depends on lse_pkg.
module lse_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [lse_pkg::DIV_NUM_W-1:0]  num,
   input  logic [lse_pkg::DIV_DEN_W-1:0]         den,
   output logic                                  done,
   output logic signed [lse_pkg::REFL_W-1:0]     quot
);

   logic                               active_ff, active_in;
   logic                               done_ff, done_in;
   logic [lse_pkg::DIV_CNT_W-1:0]      cnt_ff, cnt_in;
   logic                               neg_ff, neg_in;
   logic [lse_pkg::DIV_DEN_W-1:0]      den_ff, den_in;
   logic [lse_pkg::DIV_DEN_W-1:0]      rem_ff, rem_in;
   logic [lse_pkg::DIV_NUM_W-1:0]      q_ff, q_in;
   logic signed [lse_pkg::REFL_W-1:0]  quot_ff, quot_in;
   logic [lse_pkg::DIV_DEN_W:0]        shifted;
   logic [lse_pkg::DIV_DEN_W:0]        diff;
   logic                               fits;
   logic [23:0]                        mag;

   always_comb begin
      shifted   = {rem_ff, q_ff[lse_pkg::DIV_NUM_W-1]};
      diff      = shifted - {1'b0, den_ff};
      fits      = shifted >= {1'b0, den_ff};
      mag       = (q_ff > 64'(lse_pkg::REFL_MAX)) ? lse_pkg::REFL_MAX : q_ff[23:0];
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      quot_in   = quot_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = 7'(lse_pkg::DIV_NUM_W);
         neg_in    = num[lse_pkg::DIV_NUM_W-1];
         den_in    = den;
         rem_in    = '0;
         q_in      = num[lse_pkg::DIV_NUM_W-1] ? 64'(-num) : 64'(num);
      end else if (active_ff && cnt_ff != '0) begin
         rem_in = fits ? diff[lse_pkg::DIV_DEN_W-1:0] : shifted[lse_pkg::DIV_DEN_W-1:0];
         q_in   = {q_ff[lse_pkg::DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff - 7'd1;
      end else if (active_ff) begin
         active_in = 1'b0;
         done_in   = 1'b1;
         quot_in   = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== hw/rtl/lpc_signal_extrapolator_unit.sv =====
// Top level of the LPC signal extrapolator: sequencer, shared multiplier and MAC,
// history, autocorrelation and coefficient RAMs. Depends on lse_pkg, lse_ram, lse_div.
//
// A push, clear or ignored word is taken while idle and busy stays low. An emit
// word with coefficients ready streams its 24 taps through the single
// multiply-accumulate pipeline and waits for its drain. The first emit after new
// history with a long enough window also runs the estimate, which includes the
// autocorrelation pass (one product a cycle from two history RAM ports), the
// serial divider per order and the read-modify-write coefficient updates. Each
// result is shown for one cycle on rsp_valid and the receiver cannot stall it.
// Configuration must be written only while busy is low.
module lpc_signal_extrapolator_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_kind,
   input  logic signed [15:0] req_sample_in,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_sample_out,
   output logic               rsp_short_history,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   typedef enum logic [4:0] {
      S_IDLE, S_AC_RUN, S_NORM, S_SC_RD, S_SC_WR, S_ZERO,
      S_LV_CHECK, S_LV_ACC0, S_LV_DOT, S_LV_DIV,
      S_UP_RD, S_UP_CAP, S_UP_M1, S_UP_M2, S_UP_M3, S_UP_M4,
      S_ERR1, S_ERR2, S_ERR3, S_ERR4, S_ERR5,
      S_DM_RD, S_DM_CAP, S_DM_M1, S_DM_M2, S_DM_M3, S_DM_M4,
      S_PR
   } state_type;

   state_type                     state_ff, state_in;
   logic [lse_pkg::COUNT_W-1:0]   hist_limit_ff, hist_limit_in;
   logic [lse_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [lse_pkg::RING_AW-1:0]   wp_ff, wp_in;
   logic                          ready_ff, ready_in;
   logic [lse_pkg::COUNT_W-1:0]   n_ff, n_in;
   logic [lse_pkg::RING_AW-1:0]   base_ff, base_in;
   logic [lse_pkg::COUNT_W-1:0]   cnt_ff, cnt_in;
   logic [4:0]                    lag_ff, lag_in;
   logic [4:0]                    j_ff, j_in;
   logic                          v1_ff, v1_in, v2_ff, v2_in;
   logic signed [63:0]            acc_ff, acc_in;
   logic [lse_pkg::ACF_W-1:0]     norm_ff, norm_in;
   logic [5:0]                    shift_ff, shift_in;
   logic                          dir_right_ff, dir_right_in;
   logic signed [31:0]            err_ff, err_in;
   logic signed [lse_pkg::REFL_W-1:0] r_ff, r_in;
   logic signed [31:0]            t_ff, t_in, u_ff, u_in;
   logic signed [31:0]            op1_ff, op1_in, op2_ff, op2_in;
   logic signed [31:0]            d_ff, d_in;
   logic signed [63:0]            prod_ff;
   logic                          div_go_ff, div_go_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]            rsp_sample_ff, rsp_sample_in;
   logic                          rsp_short_ff, rsp_short_in;

   // RAM ports
   logic                          ring_we;
   logic [lse_pkg::RING_AW-1:0]   ring_wa, ring_ra, ring_rb;
   logic [15:0]                   ring_wd, ring_qa, ring_qb;
   logic                          acf_we;
   logic [lse_pkg::COEF_AW-1:0]   acf_wa, acf_ra;
   logic [lse_pkg::ACF_W-1:0]     acf_wd, acf_q;
   logic                          coef_we;
   logic [lse_pkg::COEF_AW-1:0]   coef_wa, coef_ra, coef_rb;
   logic [lse_pkg::COEF_W-1:0]    coef_wd, coef_qa, coef_qb;

   logic                          div_done;
   logic signed [lse_pkg::REFL_W-1:0] div_quot;

   logic signed [31:0]            mul_x, mul_y;
   logic                          issue, mac_idle, accept, cfg_wr;
   logic [lse_pkg::COUNT_W-1:0]   lim, win;
   logic signed [63:0]            rnd, neg_y, rnd_p, rnd30_p;
   logic signed [lse_pkg::ACF_W-1:0] acf_s;

   assign accept = start && !busy;
   assign cfg_wr = psel && penable && pwrite && pready;

   lse_ram #(.DEPTH(lse_pkg::RING_DEPTH), .WIDTH(lse_pkg::SAMPLE_W)) u_ring (
      .clock(clock), .wr_en(ring_we), .wr_addr(ring_wa), .wr_data(ring_wd),
      .rd_a_addr(ring_ra), .rd_a_data(ring_qa), .rd_b_addr(ring_rb), .rd_b_data(ring_qb)
   );

   lse_ram #(.DEPTH(lse_pkg::ACF_DEPTH), .WIDTH(lse_pkg::ACF_W)) u_acf (
      .clock(clock), .wr_en(acf_we), .wr_addr(acf_wa), .wr_data(acf_wd),
      .rd_a_addr(acf_ra), .rd_a_data(acf_q), .rd_b_addr(acf_ra), .rd_b_data()
   );

   lse_ram #(.DEPTH(lse_pkg::ORDER), .WIDTH(lse_pkg::COEF_W)) u_coef (
      .clock(clock), .wr_en(coef_we), .wr_addr(coef_wa), .wr_data(coef_wd),
      .rd_a_addr(coef_ra), .rd_a_data(coef_qa), .rd_b_addr(coef_rb), .rd_b_data(coef_qb)
   );

   lse_div u_div (
      .clock(clock), .reset(reset), .start(div_go_ff),
      .num(-acc_ff), .den(err_ff[31:0]), .done(div_done), .quot(div_quot)
   );

   // operand select for the shared multiplier: streams come straight from RAM
   always_comb begin
      unique case (state_ff)
         S_AC_RUN: begin
            mul_x = 32'($signed(ring_qa));
            mul_y = 32'($signed(ring_qb));
         end
         S_LV_DOT: begin
            mul_x = $signed(coef_qa);
            mul_y = $signed(acf_q[31:0]);
         end
         S_PR: begin
            mul_x = $signed(coef_qa);
            mul_y = 32'($signed(ring_qa));
         end
         default: begin
            mul_x = op1_ff;
            mul_y = op2_ff;
         end
      endcase
   end

   always_comb begin
      lim   = (hist_limit_ff > 10'(lse_pkg::RING_DEPTH)) ? 10'(lse_pkg::RING_DEPTH)
                                                        : hist_limit_ff;
      win   = (count_ff > lim) ? lim : count_ff;
      acf_s = dir_right_ff ? ($signed(acf_q) >>> shift_ff) : ($signed(acf_q) <<< shift_ff);
      rnd   = lse_pkg::round24(acc_ff);
      neg_y = -rnd;
      rnd_p   = lse_pkg::round24(prod_ff);
      rnd30_p = lse_pkg::round30(prod_ff);

      unique case (state_ff)
         S_AC_RUN: issue = cnt_ff < n_ff;
         S_LV_DOT: issue = cnt_ff < 10'(lag_ff);
         S_PR:     issue = cnt_ff < 10'(lse_pkg::ORDER);
         default:  issue = 1'b0;
      endcase
      mac_idle = !issue && !v1_ff && !v2_ff;

      state_in      = state_ff;
      hist_limit_in = hist_limit_ff;
      count_in      = count_ff;
      wp_in         = wp_ff;
      ready_in      = ready_ff;
      n_in          = n_ff;
      base_in       = base_ff;
      cnt_in        = cnt_ff;
      lag_in        = lag_ff;
      j_in          = j_ff;
      v1_in         = 1'b0;
      v2_in         = v1_ff;
      acc_in        = acc_ff;
      norm_in       = norm_ff;
      shift_in      = shift_ff;
      dir_right_in  = dir_right_ff;
      err_in        = err_ff;
      r_in          = r_ff;
      t_in          = t_ff;
      u_in          = u_ff;
      op1_in        = op1_ff;
      op2_in        = op2_ff;
      d_in          = d_ff;
      div_go_in     = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_sample_in = rsp_sample_ff;
      rsp_short_in  = rsp_short_ff;

      ring_we = 1'b0;
      ring_wa = wp_ff;
      ring_wd = req_sample_in;
      ring_ra = base_ff + cnt_ff[lse_pkg::RING_AW-1:0];
      ring_rb = base_ff + cnt_ff[lse_pkg::RING_AW-1:0] - 9'(lag_ff);
      acf_we  = 1'b0;
      acf_wa  = lag_ff;
      acf_wd  = acc_ff[lse_pkg::ACF_W-1:0];
      acf_ra  = j_ff;
      coef_we = 1'b0;
      coef_wa = j_ff;
      coef_wd = '0;
      coef_ra = j_ff;
      coef_rb = lag_ff - 5'd1 - j_ff;

      if (cfg_wr && paddr == lse_pkg::ADDR_HISTORY_LIMIT) begin
         hist_limit_in = pwdata[lse_pkg::COUNT_W-1:0];
      end

      // streamed multiply-accumulate
      if (issue) begin
         v1_in  = 1'b1;
         cnt_in = cnt_ff + 10'd1;
      end
      if (v2_ff) begin
         acc_in = lse_pkg::sat_acc(65'(acc_ff) + 65'(prod_ff));
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_kind)
                  lse_pkg::KIND_PUSH: begin
                     ring_we  = 1'b1;
                     wp_in    = wp_ff + 9'd1;
                     ready_in = 1'b0;
                     if (count_ff != 10'(lse_pkg::RING_DEPTH)) begin
                        count_in = count_ff + 10'd1;
                     end
                  end
                  lse_pkg::KIND_CLEAR: begin
                     count_in = '0;
                     wp_in    = '0;
                     ready_in = 1'b0;
                  end
                  lse_pkg::KIND_EMIT: begin
                     cnt_in = '0;
                     acc_in = '0;
                     if (ready_ff) begin
                        state_in = S_PR;
                     end else if (win < lse_pkg::MIN_WINDOW) begin
                        rsp_valid_in  = 1'b1;
                        rsp_sample_in = '0;
                        rsp_short_in  = 1'b1;
                     end else begin
                        n_in     = win;
                        base_in  = wp_ff - win[lse_pkg::RING_AW-1:0];
                        lag_in   = '0;
                        state_in = S_AC_RUN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_AC_RUN: begin
            if (mac_idle) begin
               acf_we = 1'b1;
               if (lag_ff == '0) begin
                  norm_in = acc_ff[lse_pkg::ACF_W-1:0];
               end
               if (lag_ff == 5'(lse_pkg::ORDER)) begin
                  shift_in = '0;
                  state_in = S_NORM;
               end else begin
                  lag_in = lag_ff + 5'd1;
                  cnt_in = 10'(lag_ff) + 10'd1;
                  acc_in = '0;
               end
            end
         end
         S_NORM: begin
            // walk a nonzero lag 0 into [2^30, 2^31), one bit a cycle
            if (norm_ff == '0) begin
               j_in     = '0;
               state_in = S_ZERO;
            end else if (norm_ff >= 48'h8000_0000) begin
               norm_in      = norm_ff >> 1;
               shift_in     = shift_ff + 6'd1;
               dir_right_in = 1'b1;
            end else if (norm_ff < 48'h4000_0000) begin
               norm_in      = norm_ff << 1;
               shift_in     = shift_ff + 6'd1;
               dir_right_in = 1'b0;
            end else begin
               err_in   = $signed(norm_ff[31:0]);
               j_in     = '0;
               state_in = S_SC_RD;
            end
         end
         S_SC_RD: begin
            state_in = S_SC_WR;
         end
         S_SC_WR: begin
            acf_we = 1'b1;
            acf_wa = j_ff;
            acf_wd = acf_s;
            if (j_ff == 5'(lse_pkg::ORDER)) begin
               j_in     = '0;
               state_in = S_ZERO;
            end else begin
               j_in     = j_ff + 5'd1;
               state_in = S_SC_RD;
            end
         end
         S_ZERO: begin
            coef_we = 1'b1;
            j_in    = j_ff + 5'd1;
            if (j_ff == 5'(lse_pkg::ORDER - 1)) begin
               j_in   = '0;
               lag_in = '0;
               d_in   = lse_pkg::DAMP_Q30;
               state_in = (norm_ff == '0) ? S_DM_RD : S_LV_CHECK;
            end
         end
         S_LV_CHECK: begin
            acf_ra = lag_ff + 5'd1;
            if (lag_ff == 5'(lse_pkg::ORDER) || err_ff < 32'sd2) begin
               j_in     = '0;
               d_in     = lse_pkg::DAMP_Q30;
               state_in = S_DM_RD;
            end else begin
               state_in = S_LV_ACC0;
            end
         end
         S_LV_ACC0: begin
            acc_in   = 64'($signed(acf_q[31:0])) <<< 24;
            cnt_in   = '0;
            state_in = S_LV_DOT;
         end
         S_LV_DOT: begin
            coef_ra = cnt_ff[lse_pkg::COEF_AW-1:0];
            acf_ra  = lag_ff - cnt_ff[lse_pkg::COEF_AW-1:0];
            if (mac_idle) begin
               div_go_in = 1'b1;
               state_in  = S_LV_DIV;
            end
         end
         S_LV_DIV: begin
            if (div_done) begin
               r_in     = div_quot;
               coef_we  = 1'b1;
               coef_wa  = lag_ff;
               coef_wd  = 32'(div_quot);
               j_in     = '0;
               state_in = S_UP_RD;
            end
         end
         S_UP_RD: begin
            // the middle entry of an odd order is read on both ports; both writes agree
            state_in = (j_ff < ((lag_ff + 5'd1) >> 1)) ? S_UP_CAP : S_ERR1;
         end
         S_UP_CAP: begin
            t_in     = $signed(coef_qa);
            u_in     = $signed(coef_qb);
            op1_in   = 32'(r_ff);
            op2_in   = $signed(coef_qb);
            state_in = S_UP_M1;
         end
         S_UP_M1: state_in = S_UP_M2;
         S_UP_M2: begin
            coef_we  = 1'b1;
            coef_wd  = lse_pkg::sat32(65'(t_ff) + 65'(rnd_p));
            op2_in   = t_ff;
            state_in = S_UP_M3;
         end
         S_UP_M3: state_in = S_UP_M4;
         S_UP_M4: begin
            coef_we  = 1'b1;
            coef_wa  = lag_ff - 5'd1 - j_ff;
            coef_wd  = lse_pkg::sat32(65'(u_ff) + 65'(rnd_p));
            j_in     = j_ff + 5'd1;
            state_in = S_UP_RD;
         end
         S_ERR1: begin
            op1_in   = 32'(r_ff);
            op2_in   = 32'(r_ff);
            state_in = S_ERR2;
         end
         S_ERR2: state_in = S_ERR3;
         S_ERR3: begin
            op1_in   = err_ff;
            op2_in   = rnd_p[31:0];
            state_in = S_ERR4;
         end
         S_ERR4: state_in = S_ERR5;
         S_ERR5: begin
            err_in   = err_ff - rnd_p[31:0];
            lag_in   = lag_ff + 5'd1;
            state_in = S_LV_CHECK;
         end
         S_DM_RD: state_in = S_DM_CAP;
         S_DM_CAP: begin
            op1_in   = $signed(coef_qa);
            op2_in   = d_ff;
            state_in = S_DM_M1;
         end
         S_DM_M1: state_in = S_DM_M2;
         S_DM_M2: begin
            coef_we  = 1'b1;
            coef_wd  = lse_pkg::sat32(65'(rnd30_p));
            op1_in   = d_ff;
            op2_in   = lse_pkg::DAMP_Q30;
            state_in = S_DM_M3;
         end
         S_DM_M3: state_in = S_DM_M4;
         S_DM_M4: begin
            d_in = rnd30_p[31:0];
            if (j_ff == 5'(lse_pkg::ORDER - 1)) begin
               ready_in = 1'b1;
               cnt_in   = '0;
               acc_in   = '0;
               state_in = S_PR;
            end else begin
               j_in     = j_ff + 5'd1;
               state_in = S_DM_RD;
            end
         end
         S_PR: begin
            coef_ra = cnt_ff[lse_pkg::COEF_AW-1:0];
            ring_ra = wp_ff - 9'd1 - cnt_ff[lse_pkg::RING_AW-1:0];
            if (mac_idle) begin
               // saturate, append to the history and hand out the word
               if (neg_y > 64'sd32767) begin
                  rsp_sample_in = 16'sh7FFF;
               end else if (neg_y < -64'sd32768) begin
                  rsp_sample_in = -16'sh8000;
               end else begin
                  rsp_sample_in = neg_y[15:0];
               end
               ring_we = 1'b1;
               ring_wd = rsp_sample_in;
               wp_in   = wp_ff + 9'd1;
               if (count_ff != 10'(lse_pkg::RING_DEPTH)) begin
                  count_in = count_ff + 10'd1;
               end
               rsp_valid_in = 1'b1;
               rsp_short_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         hist_limit_ff <= lse_pkg::HIST_LIMIT_RESET;
         count_ff      <= '0;
         wp_ff         <= '0;
         ready_ff      <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         div_go_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hist_limit_ff <= hist_limit_in;
         count_ff      <= count_in;
         wp_ff         <= wp_in;
         ready_ff      <= ready_in;
         v1_ff         <= v1_in;
         v2_ff         <= v2_in;
         div_go_ff     <= div_go_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      n_ff          <= n_in;
      base_ff       <= base_in;
      cnt_ff        <= cnt_in;
      lag_ff        <= lag_in;
      j_ff          <= j_in;
      acc_ff        <= acc_in;
      norm_ff       <= norm_in;
      shift_ff      <= shift_in;
      dir_right_ff  <= dir_right_in;
      err_ff        <= err_in;
      r_ff          <= r_in;
      t_ff          <= t_in;
      u_ff          <= u_in;
      op1_ff        <= op1_in;
      op2_ff        <= op2_in;
      d_ff          <= d_in;
      prod_ff       <= mul_x * mul_y;
      rsp_sample_ff <= rsp_sample_in;
      rsp_short_ff  <= rsp_short_in;
   end

   assign busy              = state_ff != S_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_out    = rsp_sample_ff;
   assign rsp_short_history = rsp_short_ff;
   assign pready            = 1'b1;
   assign prdata            = (paddr == lse_pkg::ADDR_HISTORY_LIMIT) ? 32'(hist_limit_ff) : '0;

   // a short-history word answers an emit word taken the cycle before
   a_short_from_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_short_history |-> $past(accept))
      else $error("short-history word without a fresh emit word");

   // a prediction closes a busy stretch
   a_pred_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_short_history |-> $past(busy) && !busy)
      else $error("prediction word outside a busy stretch");

   // the divider reports only while the sequencer waits for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_LV_DIV)
      else $error("divider result while sequencer is elsewhere");

endmodule
